// ===== hdl/srt_pkg.sv =====
// Package for the sorted record table: record, request and result types,
// operation and status codes. No dependencies.
package srt_pkg;

  localparam int NameBits = 160;

  typedef struct packed {
    logic [15:0] primary;
    logic [15:0] secondary;
    logic [63:0] name_a;
    logic [63:0] name_b;
    logic [31:0] name_c;
  } record_t;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_SORT   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_LISTING   = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  index;
    logic [15:0] key_primary;
    logic [15:0] key_secondary;
    logic [63:0] name_a;
    logic [63:0] name_b;
    logic [31:0] name_c;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  slot;
    logic [15:0] out_primary;
    logic [15:0] out_secondary;
    logic [63:0] out_name_a;
    logic [63:0] out_name_b;
    logic [31:0] out_name_c;
    logic [4:0]  fill;
    logic        last;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SORT,
    S_SEARCH,
    S_LIST,
    S_SINGLE
  } state_t;

  // Cell control from the sequencer.
  typedef struct packed {
    logic load;     // write the new record into the cell at the fill position
    logic shift;    // delete: cells at or above index, below the top record, take their upper neighbor
    logic sort_even;
    logic sort_odd;
    logic rotate;   // cells move one place down, cell 0 wraps to the top
  } cell_ctrl_t;

  function automatic logic rec_gt(record_t x, record_t y);
    return (x.primary > y.primary) ||
           ((x.primary == y.primary) && (x.secondary > y.secondary));
  endfunction

  // C string compare of two names over nbytes bytes
  function automatic logic name_eq(logic [NameBits-1:0] x, logic [NameBits-1:0] y,
                                   int nbytes);
    logic eq;
    logic done;
    eq = 1'b1;
    done = 1'b0;
    for (int i = 0; i < 20; i++) begin
      if (!done && i < nbytes) begin
        if (x[8*i +: 8] != y[8*i +: 8]) begin
          eq = 1'b0;
          done = 1'b1;
        end else if (x[8*i +: 8] == 8'd0) begin
          done = 1'b1;
        end
      end
    end
    return eq;
  endfunction

endpackage

// ===== hdl/srt_if.sv =====
// Valid/ready channel interface carrying a payload of type T.
// Depends on nothing.
interface srt_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/sorted_record_table_core.sv =====
// Sorted record table: a chain of DEPTH record cells with a sequencer.
// Request channel in, result channel out, one record per result.
// One request is worked at a time; the next is taken once the sequencer is
// back in idle and the output register is free.
// Append and delete: the chain is updated at the accept, then the listing of
// all fill records follows, one record per cycle the receiver takes; the first
// result is registered in the cycle after the accept.
// Sort: odd-even transposition passes after the accept, then the listing.
// Search: a rotation of all records through cell 0 that leaves the chain in
// place, then one result. Error answers (full, bad index, not found in an
// empty table) are one result. A delete of the only record or a sort of an
// empty table gives no result.
// Reset empties the table (fill count zero; cell contents stay undefined)
// and holds the request channel off while it lasts.
// When the receiver stalls the output register holds and the chain waits.
// Depends on srt_pkg, srt_if, srt_cell.
module sorted_record_table_core #(
  parameter int DEPTH = 16,
  parameter int NAME_BYTES = 20
) (
  input logic clk,
  input logic rst,
  srt_if.sink   req,
  srt_if.source rsp
);
  localparam int CW = $clog2(DEPTH + 1);

  srt_pkg::record_t cells [DEPTH];
  srt_pkg::cell_ctrl_t ctrl;
  srt_pkg::state_t state, state_next;
  logic [CW-1:0] fill, cnt;
  logic [6:0] fill7;
  srt_pkg::record_t new_rec;
  logic [159:0] key_name;
  logic found;
  logic [3:0] found_slot;
  srt_pkg::record_t found_rec;
  logic ovalid;
  srt_pkg::status_t single_status;

  assign fill7 = 7'(fill);

  always_comb begin
    logic [159:0] nm;
    nm = {req.data.name_c, req.data.name_b, req.data.name_a};
    for (int i = 0; i < 20; i++) if (i >= NAME_BYTES) nm[8*i +: 8] = 8'd0;
    new_rec.primary = req.data.key_primary;
    new_rec.secondary = req.data.key_secondary;
    new_rec.name_a = nm[63:0];
    new_rec.name_b = nm[127:64];
    new_rec.name_c = nm[159:128];
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    srt_pkg::record_t lo, up;
    if (g == 0) begin : g_lo0
      assign lo = cells[0];
    end else begin : g_lo
      assign lo = cells[g-1];
    end
    if (g == DEPTH - 1) begin : g_upt
      assign up = cells[g];
    end else begin : g_up
      assign up = cells[g+1];
    end
    srt_cell #(.Pos(g)) u_cell (
      .clk(clk), .ctrl(ctrl), .fill_pos(fill7), .del_index(7'(req.data.index)),
      .new_rec(new_rec), .lower(lo), .upper(up), .wrap(cells[0]),
      .upper_ok(7'(g + 1) < fill7), .is_top(7'(g + 1) == fill7 || g == DEPTH - 1),
      .rec(cells[g])
    );
  end

  logic accept, out_free, out_load;
  assign out_free = !ovalid || rsp.ready;
  assign out_load = out_free && (state == srt_pkg::S_LIST || state == srt_pkg::S_SINGLE);
  assign accept = req.valid && req.ready;
  assign req.ready = !rst && (state == srt_pkg::S_IDLE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) state <= srt_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    unique case (state)
      srt_pkg::S_IDLE: if (accept) begin
        unique case (srt_pkg::op_t'(req.data.op))
          srt_pkg::OP_APPEND: begin
            if (fill >= CW'(DEPTH)) state_next = srt_pkg::S_SINGLE;
            else begin ctrl.load = 1'b1; state_next = srt_pkg::S_LIST; end
          end
          srt_pkg::OP_DELETE: begin
            if (CW'(req.data.index) >= fill || 32'(req.data.index) >= DEPTH)
              state_next = srt_pkg::S_SINGLE;
            else begin
              ctrl.shift = 1'b1;
              state_next = (fill == CW'(1)) ? srt_pkg::S_IDLE : srt_pkg::S_LIST;
            end
          end
          srt_pkg::OP_SEARCH: state_next = (fill == '0) ? srt_pkg::S_SINGLE
                                                         : srt_pkg::S_SEARCH;
          srt_pkg::OP_SORT: state_next = (fill == '0) ? srt_pkg::S_IDLE
                                                       : srt_pkg::S_SORT;
          default: ;
        endcase
      end
      srt_pkg::S_SORT: begin
        ctrl.sort_even = !cnt[0];
        ctrl.sort_odd = cnt[0];
        if (cnt == CW'(DEPTH - 1)) state_next = srt_pkg::S_LIST;
      end
      srt_pkg::S_SEARCH: begin
        ctrl.rotate = 1'b1;
        if (cnt + CW'(1) == fill) state_next = srt_pkg::S_SINGLE;
      end
      srt_pkg::S_LIST: if (out_free) begin
        ctrl.rotate = 1'b1;
        if (cnt + CW'(1) == fill) state_next = srt_pkg::S_IDLE;
      end
      srt_pkg::S_SINGLE: if (out_free) state_next = srt_pkg::S_IDLE;
      default: state_next = srt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      cnt <= '0;
      ovalid <= 1'b0;
      found <= 1'b0;
    end else begin
      if (out_load) ovalid <= 1'b1;
      else if (rsp.ready) ovalid <= 1'b0;
      if (state != state_next) cnt <= '0;
      else if (ctrl.rotate || ctrl.sort_even || ctrl.sort_odd) cnt <= cnt + CW'(1);
      if (ctrl.load) fill <= fill + CW'(1);
      if (ctrl.shift) fill <= fill - CW'(1);
      if (accept) begin
        found <= 1'b0;
        key_name <= {new_rec.name_c, new_rec.name_b, new_rec.name_a};
        single_status <= (req.data.op == srt_pkg::OP_APPEND) ? srt_pkg::ST_FULL :
                         (req.data.op == srt_pkg::OP_DELETE) ? srt_pkg::ST_BAD_INDEX :
                         srt_pkg::ST_NOT_FOUND;
      end
      if (state == srt_pkg::S_SEARCH && !found &&
          srt_pkg::name_eq(key_name, {cells[0].name_c, cells[0].name_b, cells[0].name_a},
                           NAME_BYTES)) begin
        found <= 1'b1;
        found_slot <= 4'(cnt);
        found_rec <= cells[0];
        single_status <= srt_pkg::ST_FOUND;
      end
      if (state == srt_pkg::S_LIST && out_free) begin
        rsp.data.status <= srt_pkg::ST_LISTING;
        rsp.data.slot <= 4'(cnt);
        rsp.data.out_primary <= cells[0].primary;
        rsp.data.out_secondary <= cells[0].secondary;
        rsp.data.out_name_a <= cells[0].name_a;
        rsp.data.out_name_b <= cells[0].name_b;
        rsp.data.out_name_c <= cells[0].name_c;
        rsp.data.fill <= 5'(fill);
        rsp.data.last <= (cnt + CW'(1) == fill);
      end
      if (state == srt_pkg::S_SINGLE && out_free) begin
        rsp.data.status <= single_status;
        rsp.data.slot <= found ? found_slot : 4'd0;
        rsp.data.out_primary <= found ? found_rec.primary : 16'd0;
        rsp.data.out_secondary <= found ? found_rec.secondary : 16'd0;
        rsp.data.out_name_a <= found ? found_rec.name_a : 64'd0;
        rsp.data.out_name_b <= found ? found_rec.name_b : 64'd0;
        rsp.data.out_name_c <= found ? found_rec.name_c : 32'd0;
        rsp.data.fill <= 5'(fill);
        rsp.data.last <= 1'b1;
      end
    end
  end

  assign rsp.valid = ovalid;

  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill <= CW'(DEPTH))
    else $error("fill count above depth");
  a_idle_when_ready: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> state == srt_pkg::S_IDLE) else $error("ready outside idle");
  a_fill_stable: assert property (@(posedge clk) disable iff (rst)
    (state != srt_pkg::S_IDLE) |=> $stable(fill)) else $error("fill moved while busy");
endmodule

// ===== hdl/srt_cell.sv =====
// One record cell of the table chain: load, shift, compare-exchange, rotate.
// Depends on srt_pkg.
module srt_cell #(
  parameter int Pos = 0
) (
  input  logic               clk,
  input  srt_pkg::cell_ctrl_t ctrl,
  input  logic [6:0]         fill_pos,
  input  logic [6:0]         del_index,
  input  srt_pkg::record_t   new_rec,
  input  srt_pkg::record_t   lower,
  input  srt_pkg::record_t   upper,
  input  srt_pkg::record_t   wrap,
  input  logic               upper_ok,
  input  logic               is_top,
  output srt_pkg::record_t   rec
);
  logic even_lo;
  assign even_lo = ((Pos % 2) == 0);

  always_ff @(posedge clk) begin
    if (ctrl.load && fill_pos == 7'(Pos)) begin
      rec <= new_rec;
    end else if (ctrl.shift && 7'(Pos) >= del_index && upper_ok) begin
      rec <= upper;
    end else if (ctrl.rotate) begin
      rec <= is_top ? wrap : upper;
    end else if ((ctrl.sort_even && even_lo) || (ctrl.sort_odd && !even_lo)) begin
      if (upper_ok && srt_pkg::rec_gt(rec, upper)) rec <= upper;
    end else if ((ctrl.sort_even && !even_lo) || (ctrl.sort_odd && even_lo)) begin
      if (Pos > 0 && srt_pkg::rec_gt(lower, rec)) rec <= lower;
    end
  end
endmodule
